FILE: rtl/fdnr_pkg.sv
// Package with the types, constants and arithmetic helpers of the Newton-Raphson divider.
package fdnr_pkg;

    localparam int REFINE_STEPS = 3;
    // Stage 0 decodes, each refinement takes three stages, the last stage rounds the product.
    localparam int NUM_STAGES   = 3 * REFINE_STEPS + 2;
    localparam int LAST_STAGE   = NUM_STAGES - 1;

    localparam logic [31:0] QNAN_CANON = 32'h7FC0_0000;
    localparam logic [7:0]  EXP_ONES   = 8'hFF;
    localparam logic [9:0]  EXP_BIAS   = 10'd127;
    localparam logic [9:0]  EXP_MAX    = 10'd254;

    // Positive normal value: m * 2^(e - 23), m carries the hidden one in bit 23.
    typedef struct packed {
        logic signed [9:0] e;
        logic [23:0]       m;
    } fval_t;

    typedef struct packed {
        logic        spec;
        logic [31:0] res;
        logic        sign;
        logic [7:0]  aexp;
        logic [22:0] amant;
        logic [23:0] bm;
        fval_t       x;
        fval_t       t;
    } stage_t;

    // Round-to-nearest-even product of two positive normal values.
    function automatic fval_t fmul(input fval_t a, input fval_t b);
        logic [47:0]       p;
        logic signed [9:0] e;
        logic [23:0]       m;
        logic              r;
        logic              s;
        logic [24:0]       sum;
        fval_t             o;
        p = a.m * b.m;
        e = a.e + b.e;
        if (p[47])
        begin
            m = p[47:24];
            r = p[23];
            s = |p[22:0];
            e = e + 10'sd1;
        end
        else
        begin
            m = p[46:23];
            r = p[22];
            s = |p[21:0];
        end
        sum = {1'b0, m} + {24'd0, r & (s | m[0])};
        if (sum[24])
        begin
            o.m = 24'h80_0000;
            o.e = e + 10'sd1;
        end
        else
        begin
            o.m = sum[23:0];
            o.e = e;
        end
        return o;
    endfunction

    // Round-to-nearest-even 2 - t for t in [0.5, 2), the range the iteration keeps t in.
    function automatic fval_t fsub_two(input fval_t t);
        logic [25:0] tt;
        logic [25:0] d;
        logic [24:0] sum;
        fval_t       o;
        tt = (t.e == 10'sd0) ? {1'b0, t.m, 1'b0} : {2'b00, t.m};
        d  = 26'h200_0000 - tt;
        if (d[24])
        begin
            sum = {1'b0, d[24:1]} + {24'd0, d[0] & d[1]};
            if (sum[24])
            begin
                o.m = 24'h80_0000;
                o.e = 10'sd1;
            end
            else
            begin
                o.m = sum[23:0];
                o.e = 10'sd0;
            end
        end
        else
        begin
            o.m = d[23:0];
            o.e = -10'sd1;
        end
        return o;
    endfunction

    // Final product of the adjusted dividend and the reciprocal, with overflow and subnormals.
    function automatic logic [31:0] final_mul(input stage_t s);
        logic [47:0]       p;
        logic [47:0]       n;
        logic signed [9:0] ex;
        logic [22:0]       m;
        logic              r;
        logic              st;
        logic [30:0]       mag;
        p  = {1'b1, s.amant} * s.x.m;
        n  = p[47] ? p : {p[46:0], 1'b0};
        ex = $signed({2'b00, s.aexp}) + s.x.e + $signed({9'd0, p[47]});
        if (ex > $signed(EXP_MAX))
        begin
            mag = {EXP_ONES, 23'd0};
        end
        else
        begin
            if (ex >= 10'sd1)
            begin
                m  = n[46:24];
                r  = n[23];
                st = |n[22:0];
                mag = {ex[7:0], m};
            end
            else
            begin
                m  = n[47:25];
                r  = n[24];
                st = |n[23:0];
                mag = {8'd0, m};
            end
            mag = mag + {30'd0, r & (st | m[0])};
        end
        return {s.sign, mag};
    endfunction

endpackage

FILE: rtl/fdnr_req_if.sv
// Request channel interface carrying the dividend and divisor bit patterns.
interface fdnr_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] dividend;
    logic [31:0] divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

FILE: rtl/fdnr_rsp_if.sv
// Response channel interface carrying the quotient bit pattern.
interface fdnr_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] quotient;

    modport source (output valid, output quotient, input ready);
    modport sink   (input valid, input quotient, output ready);
endinterface

FILE: rtl/float_divide_newton_raphson.sv
// Pipelined single-precision divider built on a Newton-Raphson reciprocal.
//
// A request transaction on req carries two IEEE single bit patterns, dividend and
// divisor; each one yields exactly one response transaction on rsp with the quotient.
// NaN operands and zero divisors give the canonical quiet NaN, a zero dividend gives
// signed zero, and an out-of-range result exponent gives signed zero or infinity.
// Otherwise the divisor mantissa in [1,2) gets the estimate 1.5 - b/2, three
// refinement steps x = x * (2 - b*x), and a final product with the dividend, each
// step rounded to nearest even like a single-precision operation.
//
// The pipeline has 11 register stages: one decode stage, three per refinement step
// (multiply, subtract from two, multiply) and one for the final product. A new
// transaction may enter every cycle unless the pipeline is frozen by a stall at the
// output. The depth is set by the chain of dependent multiplies.
// Reset clears all stage valid bits, so the pipeline comes up empty. When the receiver
// holds rsp.ready low with a finished result at the output, the whole pipeline freezes
// and req.ready drops; while the output stage is empty the pipeline keeps moving.
module float_divide_newton_raphson (
    input  logic       clk,
    input  logic       rst_n,
    fdnr_req_if.sink   req,
    fdnr_rsp_if.source rsp
);

    logic                   vld_reg  [fdnr_pkg::NUM_STAGES];
    fdnr_pkg::stage_t       stg_reg  [fdnr_pkg::NUM_STAGES];
    fdnr_pkg::stage_t       stg_next [fdnr_pkg::NUM_STAGES];
    logic                   adv;

    // One enable for the whole pipeline: it moves unless a result waits at the output.
    assign adv       = !vld_reg[fdnr_pkg::LAST_STAGE] || rsp.ready;
    assign req.ready = adv;
    assign rsp.valid = vld_reg[fdnr_pkg::LAST_STAGE];
    assign rsp.quotient = stg_reg[fdnr_pkg::LAST_STAGE].res;

    // Decode stage: special cases, adjusted dividend exponent and the linear estimate.
    always_comb
    begin
        logic              a_nan;
        logic              b_nan;
        logic              b_zero;
        logic              sgn;
        logic signed [9:0] e;
        logic [24:0]       x0;
        a_nan  = (req.dividend[30:23] == fdnr_pkg::EXP_ONES) && (req.dividend[22:0] != 23'd0);
        b_nan  = (req.divisor[30:23] == fdnr_pkg::EXP_ONES) && (req.divisor[22:0] != 23'd0);
        b_zero = (req.divisor[30:0] == 31'd0);
        sgn    = req.dividend[31] ^ req.divisor[31];
        e      = $signed({2'b00, req.dividend[30:23]}) - $signed({2'b00, req.divisor[30:23]})
                 + $signed(fdnr_pkg::EXP_BIAS);
        stg_next[0]       = '0;
        stg_next[0].sign  = sgn;
        stg_next[0].aexp  = e[7:0];
        stg_next[0].amant = req.dividend[22:0];
        stg_next[0].bm    = {1'b1, req.divisor[22:0]};
        if (a_nan || b_nan || b_zero)
        begin
            stg_next[0].spec = 1'b1;
            stg_next[0].res  = fdnr_pkg::QNAN_CANON;
        end
        else if (req.dividend[30:0] == 31'd0 || e < 10'sd1)
        begin
            stg_next[0].spec = 1'b1;
            stg_next[0].res  = {sgn, 31'd0};
        end
        else if (e > $signed(fdnr_pkg::EXP_MAX))
        begin
            stg_next[0].spec = 1'b1;
            stg_next[0].res  = {sgn, fdnr_pkg::EXP_ONES, 23'd0};
        end
        // 1.5 - b/2 in units of 2^-24 is 2^24 minus the stored mantissa bits.
        x0 = 25'h100_0000 - {2'b00, req.divisor[22:0]};
        if (x0[24])
        begin
            stg_next[0].x.e = 10'sd0;
            stg_next[0].x.m = 24'h80_0000;
        end
        else
        begin
            stg_next[0].x.e = -10'sd1;
            stg_next[0].x.m = x0[23:0];
        end
    end

    for (genvar k = 1; k < fdnr_pkg::NUM_STAGES; k++)
    begin : g_stage
        always_comb
        begin
            fdnr_pkg::fval_t bv;
            bv.e = 10'sd0;
            bv.m = stg_reg[k-1].bm;
            stg_next[k] = stg_reg[k-1];
            if (k == fdnr_pkg::LAST_STAGE)
            begin
                if (!stg_reg[k-1].spec)
                begin
                    stg_next[k].res = fdnr_pkg::final_mul(stg_reg[k-1]);
                end
            end
            else if (k % 3 == 1)
            begin
                stg_next[k].t = fdnr_pkg::fmul(bv, stg_reg[k-1].x);
            end
            else if (k % 3 == 2)
            begin
                stg_next[k].t = fdnr_pkg::fsub_two(stg_reg[k-1].t);
            end
            else
            begin
                stg_next[k].x = fdnr_pkg::fmul(stg_reg[k-1].x, stg_reg[k-1].t);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fdnr_pkg::NUM_STAGES; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= req.valid;
            for (int i = 1; i < fdnr_pkg::NUM_STAGES; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < fdnr_pkg::NUM_STAGES; i++)
            begin
                stg_reg[i] <= stg_next[i];
            end
        end
    end

endmodule

FILE: tb/fdnr_quotient_checker.sv
// Checker that predicts each quotient of the divider and compares it with the response.
module fdnr_quotient_checker (
    input  logic    clk,
    input  logic    rst_n,
    fdnr_req_if     req,
    fdnr_rsp_if     rsp,
    output int      failures,
    output int      outstanding
);

    logic [31:0] expected_quotients[$];

    // Rounds the positive value sig * 2^scale to a single-precision magnitude, with
    // round-to-nearest-even, subnormals kept and overflow going to infinity.
    function automatic logic [31:0] round_to_single(input longint sig, input int scale);
        int     msb;
        int     biased;
        int     sh;
        longint q;
        longint rem;
        longint half;
        longint bits;
        msb = 0;
        for (int i = 0; i < 63; i++)
        begin
            if (sig[i])
                msb = i;
        end
        biased = msb + scale + 127;
        sh = (biased >= 1) ? msb - 23 : -149 - scale;
        if (sh <= 0)
        begin
            q = sig << (-sh);
        end
        else
        begin
            if (sh > 60)
                sh = 60;
            q    = sig >> sh;
            rem  = sig & ((64'sd1 << sh) - 1);
            half = 64'sd1 << (sh - 1);
            if (rem > half || (rem == half && q[0]))
                q = q + 1;
        end
        bits = (biased >= 1) ? q + (longint'(biased - 1) << 23) : q;
        if (bits >= 64'h7F80_0000)
            bits = 64'h7F80_0000;
        return bits[31:0];
    endfunction

    // Single-precision product of two positive values given as bit patterns.
    function automatic logic [31:0] multiply_single(input logic [31:0] a, input logic [31:0] b);
        longint pa;
        longint pb;
        int     sa;
        int     sb;
        pa = (a[30:23] == 8'd0) ? longint'(a[22:0]) : longint'({1'b1, a[22:0]});
        pb = (b[30:23] == 8'd0) ? longint'(b[22:0]) : longint'({1'b1, b[22:0]});
        sa = (a[30:23] == 8'd0) ? -149 : int'(a[30:23]) - 150;
        sb = (b[30:23] == 8'd0) ? -149 : int'(b[30:23]) - 150;
        return round_to_single(pa * pb, sa + sb);
    endfunction

    // Single-precision 2 - t for a positive normal t below two.
    function automatic logic [31:0] two_minus(input logic [31:0] t);
        longint pt;
        int     st;
        pt = longint'({1'b1, t[22:0]});
        st = int'(t[30:23]) - 150;
        return round_to_single((64'sd1 << (1 - st)) - pt, st);
    endfunction

    function automatic logic [31:0] predict_quotient(input logic [31:0] a, input logic [31:0] b);
        logic        sign;
        int          ex;
        logic [31:0] recip;
        logic [31:0] prod;
        logic [31:0] scaled;
        logic [31:0] mag;
        if ((a[30:23] == fdnr_pkg::EXP_ONES && a[22:0] != 0)
            || (b[30:23] == fdnr_pkg::EXP_ONES && b[22:0] != 0)
            || b[30:0] == 0)
            return fdnr_pkg::QNAN_CANON;
        sign = a[31] ^ b[31];
        if (a[30:0] == 0)
            return {sign, 31'd0};
        ex = int'(a[30:23]) - int'(b[30:23]) + 127;
        if (ex < 1)
            return {sign, 31'd0};
        if (ex > 254)
            return {sign, fdnr_pkg::EXP_ONES, 23'd0};
        // Linear estimate 1.5 - B/2 on a 2^-24 grid, then the refinement steps.
        recip = round_to_single(longint'(3) * (64'sd1 << 23) - longint'({1'b1, b[22:0]}), -24);
        for (int k = 0; k < fdnr_pkg::REFINE_STEPS; k++)
        begin
            prod  = multiply_single({9'h07F, b[22:0]}, recip);
            recip = multiply_single(recip, two_minus(prod));
        end
        scaled = {1'b0, ex[7:0], a[22:0]};
        mag    = multiply_single(scaled, recip);
        return {sign, mag[30:0]};
    endfunction

    assign outstanding = expected_quotients.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] want;
        if (!rst_n)
        begin
            failures = 0;
            expected_quotients.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_quotients.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected response, expected none, actual %h",
                             $time, rsp.quotient);
                end
                else
                begin
                    want = expected_quotients.pop_front();
                    if (rsp.quotient !== want)
                    begin
                        failures++;
                        $display("%0t: quotient mismatch, expected %h, actual %h",
                                 $time, want, rsp.quotient);
                    end
                end
            end
            if (req.valid && req.ready)
                expected_quotients.push_back(predict_quotient(req.dividend, req.divisor));
        end
    end
endmodule

FILE: tb/testbench.sv
// Top of the divider testbench: clock, reset, stimulus, response stalls and the verdict.
module testbench;

    logic clk;
    logic rst_n;
    int   failures;
    int   outstanding;
    int   sent;
    // While calm is set neither side inserts idle cycles.
    logic calm;

    fdnr_req_if req_ch ();
    fdnr_rsp_if rsp_ch ();

    float_divide_newton_raphson uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    fdnr_quotient_checker quotient_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // The receiver drops ready with a chance of about seven percent, except while calm is set.
    always @(posedge clk)
    begin
        rsp_ch.ready <= calm || ($urandom_range(99) >= 7);
    end

    // Offers one division and holds it until the divider takes the transaction.
    // Valid stays high between back-to-back transactions, so it is never lowered and
    // raised again within one time step.
    task automatic offer_division(input logic [31:0] a, input logic [31:0] b);
        if (!calm && $urandom_range(99) < 7)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(4) + 1) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.dividend <= a;
        req_ch.divisor  <= b;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    // Random operand bit pattern with the given biased exponent field.
    function automatic logic [31:0] with_exponent(input logic [7:0] ex);
        logic [31:0] r;
        r = $urandom;
        return {r[31], ex, r[22:0]};
    endfunction

    // Builds one random division. Most are well-formed quotients whose exponent
    // stays in range, so the refinement and the final rounding get exercised;
    // the rest are raw patterns, results near the exponent limits and specials.
    task automatic random_division();
        int          kind;
        int          ea;
        int          eb;
        logic [31:0] a;
        logic [31:0] b;
        kind = $urandom_range(99);
        if (kind < 60)
        begin
            ea = $urandom_range(254, 1);
            eb = ea - 127 + $urandom_range(250, 4) - 127 + 127;
            eb = (eb < 1) ? 1 : (eb > 254) ? 254 : eb;
            eb = ea + 127 - $urandom_range(250, 4);
            eb = (eb < 0) ? 0 : (eb > 255) ? 255 : eb;
            a = with_exponent(ea[7:0]);
            b = with_exponent(eb[7:0]);
        end
        else if (kind < 75)
        begin
            a = $urandom;
            b = $urandom;
        end
        else if (kind < 90)
        begin
            // The exponent difference lands on or next to the zero and infinity limits.
            ea = $urandom_range(255);
            eb = ea + 127 - ($urandom_range(1) ? $urandom_range(2) : 254 + $urandom_range(2));
            eb = (eb < 0) ? 0 : (eb > 255) ? 255 : eb;
            a = with_exponent(ea[7:0]);
            b = with_exponent(eb[7:0]);
        end
        else
        begin
            a = $urandom;
            b = $urandom;
            case ($urandom_range(5))
                0: a = {a[31], 31'd0};
                1: b = {b[31], 31'd0};
                2: a = {a[31], fdnr_pkg::EXP_ONES, ($urandom_range(1) ? 23'd0 : a[22:0])};
                3: b = {b[31], fdnr_pkg::EXP_ONES, ($urandom_range(1) ? 23'd0 : b[22:0])};
                4: a = {a[31], 8'd0, a[22:0]};
                default: b = {b[31], 8'd0, b[22:0]};
            endcase
        end
        offer_division(a, b);
    endtask

    initial
    begin
        logic [31:0] directed_pairs[$];
        int          waited;
        rst_n           = 1'b0;
        calm            = 1'b0;
        sent            = 0;
        req_ch.valid    = 1'b0;
        req_ch.dividend = 32'd0;
        req_ch.divisor  = 32'd0;
        rsp_ch.ready    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pairs: NaN operands, zero divisors of either sign, zero over zero,
        // zero dividends, infinities, subnormals, exponent underflow and overflow,
        // extreme mantissas and plain quotients.
        directed_pairs = '{
            32'h7FC0_0000, 32'h3F80_0000,  32'h3F80_0000, 32'hFFFF_FFFF,
            32'h4000_0000, 32'h0000_0000,  32'hC000_0000, 32'h8000_0000,
            32'h0000_0000, 32'h0000_0000,  32'h8000_0000, 32'h4040_0000,
            32'h7F80_0000, 32'hFF80_0000,  32'h7F80_0000, 32'h3F80_0000,
            32'h3F80_0000, 32'h7F80_0000,  32'h0000_0001, 32'h3F80_0000,
            32'h3F80_0000, 32'h007F_FFFF,  32'h0080_0000, 32'h7F7F_FFFF,
            32'h7F7F_FFFF, 32'h0080_0000,  32'h3F80_0000, 32'h3F80_0000,
            32'h3F80_0000, 32'h4040_0000,  32'hBFFF_FFFF, 32'h3FFF_FFFF,
            32'h4120_0000, 32'hC0E0_0000,  32'h3F00_0000, 32'h3FC0_0000,
            32'h0000_0000, 32'h7F80_0000,  32'h7F80_0001, 32'h0000_0000,
            32'h3F80_0000, 32'h7F00_0000,  32'h7F00_0000, 32'h3E80_0000,
            32'h0040_0000, 32'h4000_0000
        };
        for (int i = 0; i < directed_pairs.size(); i += 2)
            offer_division(directed_pairs[i], directed_pairs[i + 1]);

        // Hold off until the pipeline has drained completely.
        req_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);

        for (int i = 0; i < 1100; i++)
        begin
            calm = (i >= 400 && i < 600);
            random_division();
        end
        calm = 1'b0;
        req_ch.valid <= 1'b0;

        waited = 0;
        while (outstanding != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);

        $display("Sent %0d divisions: specials, zero and infinity limits, subnormals,", sent);
        $display("random operands and stalls on both channels; %0d left pending.", outstanding);
        if (failures == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d transactions pending.", outstanding);
        $display("FAIL");
        $finish;
    end
endmodule

FILE: float_divide_newton_raphson.f
rtl/fdnr_pkg.sv
rtl/fdnr_req_if.sv
rtl/fdnr_rsp_if.sv
rtl/float_divide_newton_raphson.sv
tb/fdnr_quotient_checker.sv
tb/testbench.sv
